// ----- rtl/core/aarm_pkg.sv -----
// Shared constants of the axis-angle rotation matrix core: sine series and reciprocal tables.
package aarm_pkg;

    // Number of nested terms in the sine series
    localparam int N_TERMS = 6;

    // pi/2 and one in Q2.30
    localparam logic [30:0] C_HALF_PI = 31'd1686629713;
    localparam logic [30:0] C_Q30     = 31'h4000_0000;

    // Exact floor division of a 32-bit value by 156, 110, 72, 42, 20 and 6:
    // q = (y * C_DIV_MUL) >> C_DIV_SHIFT
    localparam logic [32:0] C_DIV_MUL [N_TERMS] = '{
        33'd7048151461,
        33'd4997780127,
        33'd7635497416,
        33'd6544712071,
        33'd6871947674,
        33'd5726623062
    };
    localparam int C_DIV_SHIFT [N_TERMS] = '{40, 39, 39, 38, 37, 35};

endpackage

// ----- rtl/core/axis_angle_rotation_matrix_core.sv -----
// Top level: pipelined Rodrigues 3x3 rotation matrix builder with stream ports.
//
// Use: each transaction on the slave stream carries a unit axis and either an
// angle (s_axis_tuser = 0) or a cosine (s_axis_tuser = 1); the block returns one
// transaction on the master stream with the nine matrix elements m00..m22 in
// signed Q1.(ELEMENT_WIDTH-2), each saturated to plus or minus one.
// Angle mode builds s = sin(-angle) and c = cos(angle) from two polynomial sine
// lanes; cosine mode takes c as given and s = sqrt(1 - c*c), rounded.
// Throughput: one transaction per cycle while the receiver holds m_axis_tready high.
// The square root, one result bit per stage, sets the pipeline depth at wide
// elements; the sine series, with two multiplies per term, sets it at narrow
// ones. Shorter lanes ride along in the same stages.
// Every stage carries a valid bit. A stage loads whenever it is empty or the
// stage after it moves, so a stalled receiver fills bubbles before the slave
// side sees s_axis_tready fall; nothing is lost or repeated under stall.
// Reset (i_rst_n low at a clock edge) clears all valid bits; payload registers
// are not reset and the master side shows no transaction until new input.
module axis_angle_rotation_matrix_core #(
    parameter int ELEMENT_WIDTH = 16,
    parameter int ANGLE_WIDTH   = 16,
    localparam int IN_W  = ((4 * ELEMENT_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((9 * ELEMENT_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // axis_x, axis_y, axis_z, turn_angle, cosine_in, zero padding
    input  logic [IN_W-1:0]  s_axis_tdata,
    // command
    input  logic [0:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero padding
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int EW  = ELEMENT_WIDTH;
    localparam int EW1 = EW + 1;
    localparam int AW  = ANGLE_WIDTH;
    localparam int F   = EW - 2;
    localparam int NB  = F + 1;           // square root result bits
    localparam int W2  = 2 * F + 2;       // square root remainder width
    localparam int PW  = 2 * EW + 2;      // product width
    localparam int RS  = (F < 30) ? (30 - F) : 0;
    localparam int RH  = (F < 30) ? (29 - F) : 0;

    // Stage numbers
    localparam int ST_SQRND = 4 + NB;
    localparam int ST_SEL   = (ST_SQRND + 1 > 18) ? (ST_SQRND + 1) : 18;
    localparam int NS       = ST_SEL + 5;

    // Product slots
    localparam int P_XX = 0;
    localparam int P_XY = 1;
    localparam int P_XZ = 2;
    localparam int P_YY = 3;
    localparam int P_YZ = 4;
    localparam int P_ZZ = 5;
    localparam int P_XS = 6;
    localparam int P_YS = 7;
    localparam int P_ZS = 8;

    localparam logic [EW-1:0]    ONE_E     = EW'(1) << F;
    localparam logic [EW-1:0]    NEG_ONE_E = ~ONE_E + 1'b1;
    localparam logic [EW:0]      ONE_E1    = EW1'(1) << F;
    localparam logic [EW+1:0]    ONE_E2    = (EW + 2)'(1) << F;
    localparam logic [EW+1:0]    NEG_E2    = ~ONE_E2 + 1'b1;
    localparam logic [2*F:0]     ONE_SQ    = {1'b1, {(2 * F){1'b0}}};
    localparam logic [AW-2:0]    QUARTER   = {1'b1, {(AW - 2){1'b0}}};
    localparam logic [AW-1:0]    QUARTER_A = {2'b01, {(AW - 2){1'b0}}};

    typedef struct packed {
        logic                  cmd;
        logic [EW-1:0]         ux;
        logic [EW-1:0]         uy;
        logic [EW-1:0]         uz;
        logic [EW-1:0]         cv;
        logic [1:0]            neg;
        logic [1:0][30:0]      t;
        logic [1:0][30:0]      x;
        logic [1:0][31:0]      x2;
        logic [1:0][30:0]      acc;
        logic [1:0][31:0]      y;
        logic [1:0][30:0]      v;
        logic [1:0][EW-1:0]    sn;
        logic [2*F:0]          csq;
        logic [W2-1:0]         rem;
        logic [W2-1:0]         res;
        logic [EW-1:0]         cc;
        logic [EW-1:0]         ss;
        logic [EW:0]           oc;
        logic [8:0][PW-1:0]    p;
        logic [8:0][EW:0]      r1;
        logic [5:0][PW-1:0]    p2;
        logic [5:0][EW:0]      r2;
        logic [8:0][EW-1:0]    m;
    } t_stage;

    function automatic logic [EW-1:0] f_sat_in(input logic [EW-1:0] a);
        if ($signed(a) > $signed(ONE_E)) begin
            return ONE_E;
        end else if ($signed(a) < $signed(NEG_ONE_E)) begin
            return NEG_ONE_E;
        end
        return a;
    endfunction

    // Quadrant fold: {negate flag, offset scaled to Q2.30}
    function automatic logic [31:0] f_reduce(input logic [AW-1:0] a);
        logic [AW-2:0] r;
        logic [30:0]   t;
        r = {1'b0, a[AW-3:0]};
        if (a[AW-2]) begin
            r = QUARTER - r;
        end
        t = 31'(r) << (32 - AW);
        return {a[AW-1], t};
    endfunction

    function automatic logic [EW-1:0] f_sine_out(input logic [30:0] v, input logic neg);
        logic [31:0] w;
        if (F < 30) begin
            w = (32'(v) + (32'd1 << RH)) >> RS;
        end else begin
            w = 32'(v);
        end
        if (w > (32'd1 << F)) begin
            w = 32'd1 << F;
        end
        return neg ? EW'(~w + 32'd1) : EW'(w);
    endfunction

    function automatic logic [PW-1:0] f_mul(input logic [EW:0] a, input logic [EW:0] b);
        logic signed [PW-1:0] aa;
        logic signed [PW-1:0] bb;
        aa = $signed(a);
        bb = $signed(b);
        return aa * bb;
    endfunction

    // Scale back by 2^F, rounding half away from zero
    function automatic logic [EW:0] f_rnd(input logic [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] r;
        mag = p[PW-1] ? (~p + PW'(1)) : p;
        r   = (mag + (PW'(1) << (F - 1))) >> F;
        return p[PW-1] ? EW1'(~r + PW'(1)) : EW1'(r);
    endfunction

    function automatic logic [EW+1:0] f_sx0(input logic [EW-1:0] a);
        return {{2{a[EW-1]}}, a};
    endfunction

    function automatic logic [EW+1:0] f_sx1(input logic [EW:0] a);
        return {a[EW], a};
    endfunction

    function automatic logic [EW-1:0] f_sat_out(input logic [EW+1:0] s);
        if ($signed(s) > $signed(ONE_E2)) begin
            return ONE_E;
        end else if ($signed(s) < $signed(NEG_E2)) begin
            return NEG_ONE_E;
        end
        return EW'(s);
    endfunction

    t_stage     r_st [1:NS];
    t_stage     n_st [1:NS];
    logic [NS:1]   r_vld;
    logic [NS+1:1] w_rdy;

    // Ready chain: a stage takes new data when empty or when it drains onward
    assign w_rdy[NS+1] = m_axis_tready;
    genvar k;
    generate
        for (k = 1; k <= NS; k++) begin : g_rdy
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    endgenerate
    assign s_axis_tready = w_rdy[1];

    // Stage 1: capture, saturate operands, fold both angles into the first quadrant
    always_comb begin
        logic [AW-1:0] w_ang;
        logic [31:0]   w_rs;
        logic [31:0]   w_rc;
        w_ang  = s_axis_tdata[3*EW +: AW];
        w_rs   = f_reduce(w_ang);
        w_rc   = f_reduce(w_ang + QUARTER_A);
        n_st[1]        = '0;
        n_st[1].cmd    = s_axis_tuser[0];
        n_st[1].ux     = f_sat_in(s_axis_tdata[0 +: EW]);
        n_st[1].uy     = f_sat_in(s_axis_tdata[EW +: EW]);
        n_st[1].uz     = f_sat_in(s_axis_tdata[2*EW +: EW]);
        n_st[1].cv     = f_sat_in(s_axis_tdata[3*EW+AW +: EW]);
        n_st[1].neg[0] = w_rs[31];
        n_st[1].t[0]   = w_rs[30:0];
        n_st[1].neg[1] = w_rc[31];
        n_st[1].t[1]   = w_rc[30:0];
    end

    generate
        for (k = 2; k <= NS; k++) begin : g_stage
            localparam int IT = (k >= 5 && k <= 15) ? (k - 5) / 2 : 0;
            localparam int SJ = (k >= 4 && k < 4 + NB) ? (k - 4) : 0;

            always_comb begin
                logic [64:0]   w_div;
                logic [PW-1:0] w_cp;
                logic [W2-1:0] w_bit;
                logic [W2-1:0] w_sum;
                n_st[k] = r_st[k-1];
                w_div   = '0;
                w_cp    = '0;
                w_bit   = W2'(1) << (2 * (NB - 1 - SJ));
                w_sum   = r_st[k-1].res + w_bit;

                // Sine lanes: lane 0 sine of the angle, lane 1 of angle plus a quarter
                if (k == 2) begin
                    for (int l = 0; l < 2; l++) begin
                        n_st[k].x[l] = 31'((62'(r_st[k-1].t[l]) * 62'(aarm_pkg::C_HALF_PI))
                                           >> 30);
                    end
                    w_cp = f_mul({r_st[k-1].cv[EW-1], r_st[k-1].cv},
                                 {r_st[k-1].cv[EW-1], r_st[k-1].cv});
                    n_st[k].csq = w_cp[2*F:0];
                end
                if (k == 3) begin
                    for (int l = 0; l < 2; l++) begin
                        n_st[k].x2[l]  = 32'((62'(r_st[k-1].x[l]) * 62'(r_st[k-1].x[l])) >> 30);
                        n_st[k].acc[l] = aarm_pkg::C_Q30;
                    end
                    n_st[k].rem = W2'(ONE_SQ - r_st[k-1].csq);
                    n_st[k].res = '0;
                end
                if (k >= 4 && k <= 14 && (k % 2) == 0) begin
                    for (int l = 0; l < 2; l++) begin
                        n_st[k].y[l] = 32'((63'(r_st[k-1].x2[l]) * 63'(r_st[k-1].acc[l])) >> 30);
                    end
                end
                if (k >= 5 && k <= 15 && (k % 2) == 1) begin
                    for (int l = 0; l < 2; l++) begin
                        w_div = (65'(r_st[k-1].y[l]) * 65'(aarm_pkg::C_DIV_MUL[IT]))
                                >> aarm_pkg::C_DIV_SHIFT[IT];
                        n_st[k].acc[l] = aarm_pkg::C_Q30 - 31'(w_div);
                    end
                end
                if (k == 16) begin
                    for (int l = 0; l < 2; l++) begin
                        n_st[k].v[l] = 31'((62'(r_st[k-1].x[l]) * 62'(r_st[k-1].acc[l])) >> 30);
                    end
                end
                if (k == 17) begin
                    for (int l = 0; l < 2; l++) begin
                        n_st[k].sn[l] = f_sine_out(r_st[k-1].v[l], r_st[k-1].neg[l]);
                    end
                end

                // Square root, one result bit per stage, then round to nearest
                if (k >= 4 && k < 4 + NB) begin
                    if (r_st[k-1].rem >= w_sum) begin
                        n_st[k].rem = r_st[k-1].rem - w_sum;
                        n_st[k].res = (r_st[k-1].res >> 1) + w_bit;
                    end else begin
                        n_st[k].res = r_st[k-1].res >> 1;
                    end
                end
                if (k == ST_SQRND) begin
                    if (r_st[k-1].rem > r_st[k-1].res) begin
                        n_st[k].res = r_st[k-1].res + W2'(1);
                    end
                end

                // Pick c and s for the mode
                if (k == ST_SEL) begin
                    if (r_st[k-1].cmd) begin
                        n_st[k].cc = r_st[k-1].cv;
                        n_st[k].ss = EW'(r_st[k-1].res);
                    end else begin
                        n_st[k].cc = r_st[k-1].sn[1];
                        n_st[k].ss = ~r_st[k-1].sn[0] + 1'b1;
                    end
                end

                // Axis products and axis-times-sine products
                if (k == ST_SEL + 1) begin
                    n_st[k].oc = ONE_E1 - {r_st[k-1].cc[EW-1], r_st[k-1].cc};
                    n_st[k].p[P_XX] = f_mul({r_st[k-1].ux[EW-1], r_st[k-1].ux},
                                            {r_st[k-1].ux[EW-1], r_st[k-1].ux});
                    n_st[k].p[P_XY] = f_mul({r_st[k-1].ux[EW-1], r_st[k-1].ux},
                                            {r_st[k-1].uy[EW-1], r_st[k-1].uy});
                    n_st[k].p[P_XZ] = f_mul({r_st[k-1].ux[EW-1], r_st[k-1].ux},
                                            {r_st[k-1].uz[EW-1], r_st[k-1].uz});
                    n_st[k].p[P_YY] = f_mul({r_st[k-1].uy[EW-1], r_st[k-1].uy},
                                            {r_st[k-1].uy[EW-1], r_st[k-1].uy});
                    n_st[k].p[P_YZ] = f_mul({r_st[k-1].uy[EW-1], r_st[k-1].uy},
                                            {r_st[k-1].uz[EW-1], r_st[k-1].uz});
                    n_st[k].p[P_ZZ] = f_mul({r_st[k-1].uz[EW-1], r_st[k-1].uz},
                                            {r_st[k-1].uz[EW-1], r_st[k-1].uz});
                    n_st[k].p[P_XS] = f_mul({r_st[k-1].ux[EW-1], r_st[k-1].ux},
                                            {r_st[k-1].ss[EW-1], r_st[k-1].ss});
                    n_st[k].p[P_YS] = f_mul({r_st[k-1].uy[EW-1], r_st[k-1].uy},
                                            {r_st[k-1].ss[EW-1], r_st[k-1].ss});
                    n_st[k].p[P_ZS] = f_mul({r_st[k-1].uz[EW-1], r_st[k-1].uz},
                                            {r_st[k-1].ss[EW-1], r_st[k-1].ss});
                end
                if (k == ST_SEL + 2) begin
                    for (int j = 0; j < 9; j++) begin
                        n_st[k].r1[j] = f_rnd(r_st[k-1].p[j]);
                    end
                end
                if (k == ST_SEL + 3) begin
                    for (int j = 0; j < 6; j++) begin
                        n_st[k].p2[j] = f_mul(r_st[k-1].r1[j], r_st[k-1].oc);
                    end
                end
                if (k == ST_SEL + 4) begin
                    for (int j = 0; j < 6; j++) begin
                        n_st[k].r2[j] = f_rnd(r_st[k-1].p2[j]);
                    end
                end

                // Sum each element exactly, then saturate
                if (k == ST_SEL + 5) begin
                    n_st[k].m[0] = f_sat_out(f_sx0(r_st[k-1].cc) + f_sx1(r_st[k-1].r2[P_XX]));
                    n_st[k].m[1] = f_sat_out(f_sx1(r_st[k-1].r2[P_XY])
                                             - f_sx1(r_st[k-1].r1[P_ZS]));
                    n_st[k].m[2] = f_sat_out(f_sx1(r_st[k-1].r2[P_XZ])
                                             + f_sx1(r_st[k-1].r1[P_YS]));
                    n_st[k].m[3] = f_sat_out(f_sx1(r_st[k-1].r2[P_XY])
                                             + f_sx1(r_st[k-1].r1[P_ZS]));
                    n_st[k].m[4] = f_sat_out(f_sx0(r_st[k-1].cc) + f_sx1(r_st[k-1].r2[P_YY]));
                    n_st[k].m[5] = f_sat_out(f_sx1(r_st[k-1].r2[P_YZ])
                                             - f_sx1(r_st[k-1].r1[P_XS]));
                    n_st[k].m[6] = f_sat_out(f_sx1(r_st[k-1].r2[P_XZ])
                                             - f_sx1(r_st[k-1].r1[P_YS]));
                    n_st[k].m[7] = f_sat_out(f_sx1(r_st[k-1].r2[P_YZ])
                                             + f_sx1(r_st[k-1].r1[P_XS]));
                    n_st[k].m[8] = f_sat_out(f_sx0(r_st[k-1].cc) + f_sx1(r_st[k-1].r2[P_ZZ]));
                end
            end
        end
    endgenerate

    // Stage registers: advance when the stage is free, hold otherwise
    generate
        for (k = 1; k <= NS; k++) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_vld[k] <= (k == 1) ? s_axis_tvalid : r_vld[(k == 1) ? 1 : k - 1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k]) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    // Pack the result, first element in the lowest bits
    always_comb begin
        m_axis_tdata = '0;
        for (int j = 0; j < 9; j++) begin
            m_axis_tdata[j*EW +: EW] = r_st[NS].m[j];
        end
    end

    assign m_axis_tvalid = r_vld[NS];

endmodule

// ----- rtl/core/aarm_checker.sv -----
// Port-level checker for the rotation matrix core, with its bind statement.
module aarm_checker #(
    parameter int ELEMENT_WIDTH = 16,
    parameter int ANGLE_WIDTH   = 16,
    localparam int IN_W  = ((4 * ELEMENT_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((9 * ELEMENT_WIDTH + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic [0:0]       s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    localparam int EW = ELEMENT_WIDTH;
    localparam logic signed [EW:0] ONE_C = (EW + 1)'(1) << (EW - 2);

    logic w_in_range;
    logic w_in_seen;

    always_comb begin
        w_in_range = 1'b1;
        for (int j = 0; j < 9; j++) begin
            if ($signed({m_axis_tdata[j*EW + EW - 1], m_axis_tdata[j*EW +: EW]}) > ONE_C ||
                $signed({m_axis_tdata[j*EW + EW - 1], m_axis_tdata[j*EW +: EW]}) < -ONE_C) begin
                w_in_range = 1'b0;
            end
        end
    end

    assign w_in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] || !s_axis_tuser[0])
                       && (s_axis_tdata == s_axis_tdata);

    // An empty or draining output never blocks the slave side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("slave side stalled while the output was free");

    // Reset drops every transaction in flight
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or vanished");

    // Every element is saturated to plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid || w_in_seen) |-> (w_in_range || !m_axis_tvalid))
        else $error("matrix element outside plus or minus one");

endmodule

bind axis_angle_rotation_matrix_core aarm_checker #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .ANGLE_WIDTH  (ANGLE_WIDTH)
) u_aarm_checker (.*);

// ----- bench/axis_angle_rotation_matrix_core_tb.sv -----
// Self-checking bench for the rotation matrix core: predicted against streamed matrices.
`timescale 1ns / 100ps

module axis_angle_rotation_matrix_core_tb;

    localparam int EW    = 16;
    localparam int AW    = 16;
    localparam int IN_W  = ((4 * EW + AW + 7) / 8) * 8;
    localparam int OUT_W = ((9 * EW + 7) / 8) * 8;
    localparam int FRAC  = EW - 2;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam longint Q30 = 64'sd1 << 30;
    localparam int LATENCY = 25;
    localparam longint CYCLE_LIMIT = 400000;

    typedef enum logic [0:0] {CMD_ANGLE = 1'b0, CMD_COSINE = 1'b1} t_cmd;

    typedef struct packed {
        logic [15:0] m22, m21, m20, m12, m11, m10, m02, m01, m00;
    } t_matrix;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // axis_x, axis_y, axis_z, turn_angle, cosine_in, zero padding
    logic [IN_W-1:0]  s_axis_tdata = '0;
    // command
    logic [0:0]       s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // m00 .. m22, zero padding
    logic [OUT_W-1:0] m_axis_tdata;

    axis_angle_rotation_matrix_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_matrix expected_matrices[$];
    int      mismatches = 0;
    longint  cycle_count = 0;
    bit      sender_idle_on = 1'b1;
    bit      receiver_idle_on = 1'b1;
    int      hold_off_cycles = 0;
    int      rx_idle_left = 0;

    // --- predictor ---------------------------------------------------------
    function automatic longint clamp_one(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    // product scaled back by 2^FRAC, rounding half away from zero
    function automatic longint qmul(longint a, longint b);
        longint p, mag, r;
        p = a * b;
        mag = (p < 0) ? -p : p;
        r = (mag + (64'sd1 << (FRAC - 1))) >>> FRAC;
        return (p < 0) ? -r : r;
    endfunction

    function automatic longint poly_sine(logic [AW-1:0] ang);
        longint unsigned quarter, q, r, x, x2, acc, v;
        longint unsigned dv[6];
        dv = '{156, 110, 72, 42, 20, 6};
        quarter = 64'd1 << (AW - 2);
        q = ang >> (AW - 2);
        r = ang & (quarter - 1);
        if (q[0]) r = quarter - r;
        x = ((r << (32 - AW)) * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        acc = Q30;
        for (int k = 0; k < 6; k++) acc = Q30 - ((x2 * acc) >> 30) / dv[k];
        v = (x * acc) >> 30;
        v = (v + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
        if (v > ONE) v = ONE;
        return q[1] ? -longint'(v) : longint'(v);
    endfunction

    function automatic longint rounded_root(longint unsigned v);
        longint unsigned res, rem, b;
        res = 0;
        rem = v;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        if (v - res * res > res) res++;
        return res;
    endfunction

    function automatic t_matrix rotation_of(t_cmd cmd, logic signed [15:0] ax,
            logic signed [15:0] ay, logic signed [15:0] az, logic [15:0] ang,
            logic signed [15:0] cin);
        longint ux, uy, uz, c, s, oc;
        longint m[9];
        t_matrix res;
        ux = clamp_one(longint'(ax));
        uy = clamp_one(longint'(ay));
        uz = clamp_one(longint'(az));
        if (cmd == CMD_COSINE) begin
            c = clamp_one(longint'(cin));
            s = rounded_root(ONE * ONE - c * c);
        end else begin
            s = -poly_sine(ang);
            c = poly_sine(ang + (16'd1 << (AW - 2)));
        end
        oc = ONE - c;
        m[0] = c + qmul(qmul(ux, ux), oc);
        m[1] = qmul(qmul(ux, uy), oc) - qmul(uz, s);
        m[2] = qmul(qmul(ux, uz), oc) + qmul(uy, s);
        m[3] = qmul(qmul(uy, ux), oc) + qmul(uz, s);
        m[4] = c + qmul(qmul(uy, uy), oc);
        m[5] = qmul(qmul(uy, uz), oc) - qmul(ux, s);
        m[6] = qmul(qmul(uz, ux), oc) - qmul(uy, s);
        m[7] = qmul(qmul(uz, uy), oc) + qmul(ux, s);
        m[8] = c + qmul(qmul(uz, uz), oc);
        res.m00 = 16'(clamp_one(m[0]));
        res.m01 = 16'(clamp_one(m[1]));
        res.m02 = 16'(clamp_one(m[2]));
        res.m10 = 16'(clamp_one(m[3]));
        res.m11 = 16'(clamp_one(m[4]));
        res.m12 = 16'(clamp_one(m[5]));
        res.m20 = 16'(clamp_one(m[6]));
        res.m21 = 16'(clamp_one(m[7]));
        res.m22 = 16'(clamp_one(m[8]));
        return res;
    endfunction

    // --- sender ------------------------------------------------------------
    // Offer one transaction, wait for acceptance, queue its predicted matrix.
    // tvalid stays high across back-to-back sends; drop it only before a gap.
    task automatic send_rotation(t_cmd cmd, logic [15:0] ax, logic [15:0] ay,
            logic [15:0] az, logic [15:0] ang, logic [15:0] cin);
        int gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {cin, ang, az, ay, ax};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_matrices.push_back(rotation_of(cmd, ax, ay, az, ang, cin));
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold until every matrix has returned.
    task automatic drain_results();
        pause_sender();
        while (expected_matrices.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_unit();
        case ($urandom_range(0, 5))
            0: return 16'(-16384);
            1: return 16'd16384;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // --- tests -------------------------------------------------------------
    task automatic test_directed_extremes();
        logic [15:0] angs[8];
        angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001, 16'h2000, 16'h7FFF};
        foreach (angs[i])
            send_rotation(CMD_ANGLE, 16'd0, 16'd0, 16'd16384, angs[i], 16'hFFFF);
        send_rotation(CMD_COSINE, 16'd16384, 16'd0, 16'd0, 16'hFFFF, 16'd16384);
        send_rotation(CMD_COSINE, 16'd0, 16'd16384, 16'd0, 16'd0, 16'(-16384));
        send_rotation(CMD_COSINE, 16'd0, 16'd0, 16'(-16384), 16'd0, 16'd0);
        // cosine outside plus or minus one is clamped first
        send_rotation(CMD_COSINE, 16'd9459, 16'd9459, 16'd9459, 16'd0, 16'h7FFF);
        send_rotation(CMD_COSINE, 16'd9459, 16'd9459, 16'd9459, 16'd0, 16'h8000);
        // axis components beyond one are clamped
        send_rotation(CMD_ANGLE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h1555, 16'd0);
        send_rotation(CMD_COSINE, 16'h8000, 16'h7FFF, 16'h8000, 16'hAAAA, 16'd8192);
        // non-unit axis drives elements into saturation
        send_rotation(CMD_ANGLE, 16'd16384, 16'd16384, 16'd16384, 16'h3000, 16'd0);
        send_rotation(CMD_ANGLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_rotation(CMD_COSINE, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        drain_results();
    endtask

    task automatic test_random_rotations(int count);
        for (int i = 0; i < count; i++)
            send_rotation(t_cmd'($urandom_range(0, 1)), rand_unit(), rand_unit(),
                          rand_unit(), 16'($urandom), rand_unit());
    endtask

    // Receiver holds off long enough that the pipeline fills and tready falls;
    // the sender keeps offering back to back meanwhile.
    task automatic test_backpressure();
        sender_idle_on  = 1'b0;
        hold_off_cycles = 80;
        test_random_rotations(60);
        drain_results();
        sender_idle_on  = 1'b1;
    endtask

    task automatic test_full_rate();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        test_random_rotations(150);
        drain_results();
    endtask

    // --- receiver ----------------------------------------------------------
    // Idle in bursts of random length while idling is on.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_left > 0) begin
                rx_idle_left <= rx_idle_left - 1;
                m_axis_tready <= 1'b0;
            end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
                rx_idle_left <= int'($urandom_range(0, 17));
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_matrix got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[9*16-1:0];
            if (expected_matrices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected matrix %h", got);
            end else begin
                want = expected_matrices.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("matrix mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_random_rotations(320);
        drain_results();
        test_backpressure();
        test_full_rate();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_matrices.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/aarm_pkg.sv
rtl/core/axis_angle_rotation_matrix_core.sv
rtl/core/aarm_checker.sv
bench/axis_angle_rotation_matrix_core_tb.sv
